>>> hdl/edc_pkg.sv
`default_nettype none

package edc_pkg;

    localparam int MAX_LEN_DEF = 64;

    localparam int OP_W  = 3;
    localparam int SYM_W = 8;
    localparam int RES_W = 7;

    localparam logic [OP_W-1:0] OP_BEGIN_Q = 3'd0;
    localparam logic [OP_W-1:0] OP_APPEND  = 3'd1;
    localparam logic [OP_W-1:0] OP_BEGIN_C = 3'd2;
    localparam logic [OP_W-1:0] OP_CAND    = 3'd3;
    localparam logic [OP_W-1:0] OP_FINISH  = 3'd4;

    localparam logic [1:0] TOK_BYTE = 2'd0;
    localparam logic [1:0] TOK_INIT = 2'd1;
    localparam logic [1:0] TOK_FIN  = 2'd2;

    // control part of a token travelling along the cell chain
    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic       flag;
    } edc_tok_t;

endpackage

`default_nettype wire

>>> hdl/edc_cell.sv
`default_nettype none

module edc_cell #(
    parameter int MAX_LEN = edc_pkg::MAX_LEN_DEF,
    parameter int IDX     = 0,
    localparam int LW     = $clog2(MAX_LEN + 1),
    localparam int DW     = $clog2(2 * MAX_LEN + 1)
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          en,
    input  wire  [LW-1:0]                qlen,
    input  wire                          wr_valid,
    input  wire  [edc_pkg::SYM_W-1:0]    wr_sym,
    input  edc_pkg::edc_tok_t            ctrl_in,
    input  wire  [edc_pkg::SYM_W-1:0]    sym_in,
    input  wire  [DW-1:0]                left_in,
    input  wire  [DW-1:0]                diag_in,
    input  wire  [edc_pkg::RES_W-1:0]    count_in,
    output edc_pkg::edc_tok_t            ctrl_out,
    output logic [edc_pkg::SYM_W-1:0]    sym_out,
    output logic [DW-1:0]                left_out,
    output logic [DW-1:0]                diag_out,
    output logic [edc_pkg::RES_W-1:0]    count_out
);

    edc_pkg::edc_tok_t           ctrl_reg, ctrl_next;
    logic [edc_pkg::SYM_W-1:0]   sym_reg;
    logic [DW-1:0]               left_reg, left_next;
    logic [DW-1:0]               diag_reg, diag_next;
    logic [edc_pkg::RES_W-1:0]   count_reg, count_next;
    logic [DW-1:0]               dp_reg, dp_next;
    logic [edc_pkg::SYM_W-1:0]   qbyte_reg;
    logic                        active;
    logic [DW-1:0]               min_lt;
    logic [DW-1:0]               min_all;

    assign active = (LW'(IDX) < qlen);

    always_comb begin
        min_lt  = (left_in < dp_reg) ? left_in : dp_reg;
        min_all = (min_lt < diag_in) ? min_lt : diag_in;
    end

    always_comb begin
        ctrl_next  = ctrl_in;
        left_next  = left_in;
        diag_next  = diag_in;
        count_next = count_in;
        dp_next    = dp_reg;
        if (ctrl_in.valid && active) begin
            case (ctrl_in.kind)
                edc_pkg::TOK_BYTE: begin
                    if (qbyte_reg == sym_in) begin
                        dp_next = diag_in;
                        if (diag_in == '0) begin
                            count_next = count_in + edc_pkg::RES_W'(1);
                        end
                    end else begin
                        dp_next = min_all + DW'(1);
                    end
                    left_next = dp_next;
                    diag_next = dp_reg;
                end
                edc_pkg::TOK_INIT: begin
                    dp_next = DW'(IDX + 1);
                end
                edc_pkg::TOK_FIN: begin
                    // last active cell leaves its value as the distance
                    left_next = dp_reg;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
            dp_reg   <= '0;
        end else if (en) begin
            ctrl_reg <= ctrl_next;
            dp_reg   <= dp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sym_reg   <= sym_in;
            left_reg  <= left_next;
            diag_reg  <= diag_next;
            count_reg <= count_next;
        end
        if (wr_valid && (qlen == LW'(IDX))) begin
            qbyte_reg <= wr_sym;
        end
    end

    assign ctrl_out  = ctrl_reg;
    assign sym_out   = sym_reg;
    assign left_out  = left_reg;
    assign diag_out  = diag_reg;
    assign count_out = count_reg;

endmodule

`default_nettype wire

>>> hdl/edit_distance_engine.sv
// Levenshtein edit distance engine.
// Input channel (s_valid/s_ready) carries an opcode and a symbol byte:
// begin query, append query byte, begin candidate, candidate byte, finish.
// Result channel (m_valid/m_ready) carries distance, common prefix length
// and an overflow flag, one transaction per finish.
// The table row lives in a chain of MAX_LEN cells, one per query position;
// each cell also holds its query byte. Candidate bytes, begin candidate and
// finish travel the chain as a wavefront, one cell per cycle unless the
// chain is stalled, so these can be accepted every cycle while it runs. A
// finish result is loaded into the output register when its token leaves
// the last cell. Begin query and append wait until the chain has drained.
// A finish held at the end of the chain while the output register is still
// full stalls the whole chain, and s_ready drops for wavefront opcodes.
// Unused opcodes are accepted and ignored.
// Reset (aresetn low, synchronous) empties the chain, clears the row, the
// lengths, the match count and the overflow flag; query bytes are left.
`default_nettype none

module edit_distance_engine #(
    parameter int MAX_LEN = edc_pkg::MAX_LEN_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  [edc_pkg::OP_W-1:0]     s_opcode,
    input  wire  [edc_pkg::SYM_W-1:0]    s_symbol,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [edc_pkg::RES_W-1:0]    m_distance,
    output logic [edc_pkg::RES_W-1:0]    m_common_prefix,
    output logic                         m_overflow
);

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int DW = $clog2(2 * MAX_LEN + 1);
    localparam int XW = (DW > edc_pkg::RES_W) ? DW : edc_pkg::RES_W;

    edc_pkg::edc_tok_t           ctrl_c  [0:MAX_LEN];
    logic [edc_pkg::SYM_W-1:0]   sym_c   [0:MAX_LEN];
    logic [DW-1:0]               left_c  [0:MAX_LEN];
    logic [DW-1:0]               diag_c  [0:MAX_LEN];
    logic [edc_pkg::RES_W-1:0]   count_c [0:MAX_LEN];

    logic [LW-1:0]               qlen_reg, qlen_next;
    logic [LW-1:0]               clen_reg, clen_next;
    logic [LW-1:0]               clen_inc;
    logic [DW-1:0]               dp0_reg, dp0_next;
    logic                        too_long_reg, too_long_next;
    logic [edc_pkg::RES_W-1:0]   mc_reg, mc_next;
    logic                        out_valid_reg, out_valid_next;
    logic [edc_pkg::RES_W-1:0]   out_dist_reg, out_dist_next;
    logic [edc_pkg::RES_W-1:0]   out_pref_reg, out_pref_next;
    logic                        out_ovf_reg, out_ovf_next;

    logic                        accept;
    logic                        en;
    logic                        chain_empty;
    logic                        wr_valid;
    logic                        exit_fin;
    logic [XW-1:0]               exit_dist;

    edc_pkg::edc_tok_t           exit_ctrl;

    assign exit_ctrl = ctrl_c[MAX_LEN];
    assign exit_fin  = exit_ctrl.valid && (exit_ctrl.kind == edc_pkg::TOK_FIN);
    assign exit_dist = XW'(left_c[MAX_LEN]);

    // chain holds while a finish cannot be handed to the output register
    assign en = !(exit_fin && out_valid_reg && !m_ready);

    always_comb begin
        chain_empty = 1'b1;
        for (int i = 1; i <= MAX_LEN; i++) begin
            if (ctrl_c[i].valid) begin
                chain_empty = 1'b0;
            end
        end
    end

    always_comb begin
        if (s_opcode inside {edc_pkg::OP_BEGIN_Q, edc_pkg::OP_APPEND}) begin
            s_ready = chain_empty;
        end else if (s_opcode inside {edc_pkg::OP_BEGIN_C, edc_pkg::OP_CAND,
                                      edc_pkg::OP_FINISH}) begin
            s_ready = en;
        end else begin
            s_ready = 1'b1;
        end
    end

    assign accept   = s_valid && s_ready;
    assign clen_inc = clen_reg + LW'(1);

    // head of the chain: dp_row[0] and the lengths live here
    always_comb begin
        qlen_next     = qlen_reg;
        clen_next     = clen_reg;
        dp0_next      = dp0_reg;
        too_long_next = too_long_reg;
        wr_valid      = 1'b0;
        ctrl_c[0]     = '0;
        sym_c[0]      = s_symbol;
        left_c[0]     = dp0_reg;
        diag_c[0]     = dp0_reg;
        count_c[0]    = '0;
        if (accept) begin
            case (s_opcode)
                edc_pkg::OP_BEGIN_Q: begin
                    qlen_next     = '0;
                    too_long_next = 1'b0;
                end
                edc_pkg::OP_APPEND: begin
                    if (qlen_reg == LW'(MAX_LEN)) begin
                        too_long_next = 1'b1;
                    end else begin
                        wr_valid  = 1'b1;
                        qlen_next = qlen_reg + LW'(1);
                    end
                end
                edc_pkg::OP_BEGIN_C: begin
                    dp0_next        = '0;
                    clen_next       = '0;
                    ctrl_c[0].valid = 1'b1;
                    ctrl_c[0].kind  = edc_pkg::TOK_INIT;
                end
                edc_pkg::OP_CAND: begin
                    if (clen_reg == LW'(MAX_LEN)) begin
                        too_long_next = 1'b1;
                    end else begin
                        clen_next       = clen_inc;
                        dp0_next        = DW'(clen_inc);
                        ctrl_c[0].valid = 1'b1;
                        ctrl_c[0].kind  = edc_pkg::TOK_BYTE;
                        left_c[0]       = DW'(clen_inc);
                    end
                end
                edc_pkg::OP_FINISH: begin
                    ctrl_c[0].valid = 1'b1;
                    ctrl_c[0].kind  = edc_pkg::TOK_FIN;
                    ctrl_c[0].flag  = too_long_reg;
                end
                default: begin
                end
            endcase
        end
    end

    // tail of the chain: match count and result register
    always_comb begin
        mc_next        = mc_reg;
        out_valid_next = out_valid_reg;
        out_dist_next  = out_dist_reg;
        out_pref_next  = out_pref_reg;
        out_ovf_next   = out_ovf_reg;
        if (en && exit_ctrl.valid) begin
            case (exit_ctrl.kind)
                edc_pkg::TOK_BYTE: mc_next = mc_reg + count_c[MAX_LEN];
                edc_pkg::TOK_INIT: mc_next = '0;
                default: begin
                end
            endcase
        end
        if (en && exit_fin) begin
            out_valid_next = 1'b1;
            out_dist_next  = exit_dist[edc_pkg::RES_W-1:0];
            out_pref_next  = mc_reg;
            out_ovf_next   = exit_ctrl.flag;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qlen_reg      <= '0;
            clen_reg      <= '0;
            dp0_reg       <= '0;
            too_long_reg  <= 1'b0;
            mc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            qlen_reg      <= qlen_next;
            clen_reg      <= clen_next;
            dp0_reg       <= dp0_next;
            too_long_reg  <= too_long_next;
            mc_reg        <= mc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_dist_reg <= out_dist_next;
        out_pref_reg <= out_pref_next;
        out_ovf_reg  <= out_ovf_next;
    end

    for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
        edc_cell #(
            .MAX_LEN (MAX_LEN),
            .IDX     (g)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .qlen      (qlen_reg),
            .wr_valid  (wr_valid),
            .wr_sym    (s_symbol),
            .ctrl_in   (ctrl_c[g]),
            .sym_in    (sym_c[g]),
            .left_in   (left_c[g]),
            .diag_in   (diag_c[g]),
            .count_in  (count_c[g]),
            .ctrl_out  (ctrl_c[g+1]),
            .sym_out   (sym_c[g+1]),
            .left_out  (left_c[g+1]),
            .diag_out  (diag_c[g+1]),
            .count_out (count_c[g+1])
        );
    end

    assign m_valid         = out_valid_reg;
    assign m_distance      = out_dist_reg;
    assign m_common_prefix = out_pref_reg;
    assign m_overflow      = out_ovf_reg;

endmodule

`default_nettype wire
